[hdl/olist_pkg.sv]
// olist_pkg: shared types and constants for the ordered array list unit.
// Depends on nothing; every other file of the unit refers to it by scoped name.
`timescale 1ns / 1ps

package olist_pkg;

  // Store depth and the index/count widths that the port widths follow.
  localparam int unsigned Depth  = 64;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAW    = $clog2(QDepth);

  // Request codes as they arrive on the mode port.
  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_EDIT   = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_GET    = 3'd4;
  localparam logic [2:0] MODE_SEARCH = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_APPEND,
    OP_INSERT,
    OP_EDIT,
    OP_DELETE,
    OP_GET,
    OP_SEARCH
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADIDX   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SHIFT_UP,
    BK_PLACE,
    BK_SHIFT_DN,
    BK_SCAN
  } back_state_e;

  // Decoded request as it travels from the front end to the back end.
  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] pos;
  } cmd_t;

endpackage

[hdl/olist_front.sv]
// olist_front: request intake; decodes the mode code into an operation.
// Depends on olist_pkg.
`timescale 1ns / 1ps

module olist_front (
  input  logic                        start_i,
  input  logic [2:0]                  mode_i,
  input  logic [olist_pkg::IdxW-1:0]  position_i,
  input  logic                        q_full_i,
  output logic                        busy_o,
  output logic                        push_o,
  output olist_pkg::cmd_t             cmd_o
);

  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

  always_comb begin
    cmd_o.pos = position_i;
    unique case (mode_i)
      olist_pkg::MODE_APPEND: cmd_o.op = olist_pkg::OP_APPEND;
      olist_pkg::MODE_INSERT: cmd_o.op = olist_pkg::OP_INSERT;
      olist_pkg::MODE_EDIT:   cmd_o.op = olist_pkg::OP_EDIT;
      olist_pkg::MODE_DELETE: cmd_o.op = olist_pkg::OP_DELETE;
      olist_pkg::MODE_GET:    cmd_o.op = olist_pkg::OP_GET;
      olist_pkg::MODE_SEARCH: cmd_o.op = olist_pkg::OP_SEARCH;
      default:                cmd_o.op = olist_pkg::OP_NOP; // unused codes do nothing
    endcase
  end

endmodule

[hdl/olist_queue.sv]
// olist_queue: short FIFO of decoded items between front end and back end.
// Depends on olist_pkg.
`timescale 1ns / 1ps

module olist_queue #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  olist_pkg::cmd_t      push_cmd_i,
  input  logic [WORD_BITS-1:0] push_word_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output olist_pkg::cmd_t      head_cmd_o,
  output logic [WORD_BITS-1:0] head_word_o
);

  olist_pkg::cmd_t      cmd_q  [olist_pkg::QDepth];
  logic [WORD_BITS-1:0] word_q [olist_pkg::QDepth];

  logic [olist_pkg::QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [olist_pkg::QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [olist_pkg::QAW:0]   level_q, level_d;

  assign full_o      = (level_q == (olist_pkg::QAW + 1)'(olist_pkg::QDepth));
  assign empty_o     = (level_q == '0);
  assign head_cmd_o  = cmd_q[rd_ptr_q];
  assign head_word_o = word_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    level_d  = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q]  <= push_cmd_i;
      word_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

[hdl/olist_back.sv]
// olist_back: executes list operations on the entry memory, one memory step a cycle.
// Depends on olist_pkg.
`timescale 1ns / 1ps

module olist_back #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [olist_pkg::CntW-1:0]  cfg_data_i,
  input  logic                        q_empty_i,
  input  olist_pkg::cmd_t             q_cmd_i,
  input  logic [WORD_BITS-1:0]        q_word_i,
  output logic                        q_pop_o,
  output logic                        idle_o,
  output logic                        done_o,
  output olist_pkg::status_e          status_o,
  output logic [WORD_BITS-1:0]        read_word_o,
  output logic [olist_pkg::IdxW-1:0]  found_at_o,
  output logic [olist_pkg::CntW-1:0]  fill_count_o,
  output logic                        is_full_o,
  output logic                        is_empty_o
);

  localparam int unsigned IdxW = olist_pkg::IdxW;
  localparam int unsigned CntW = olist_pkg::CntW;

  olist_pkg::back_state_e state_q, state_d;

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      cap_q, cap_d;
  logic [IdxW-1:0]      ptr_q, ptr_d;
  olist_pkg::cmd_t      cur_q, cur_d;
  logic [WORD_BITS-1:0] word_q, word_d;

  logic [WORD_BITS-1:0] mem [olist_pkg::Depth];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [IdxW-1:0]      waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [IdxW-1:0]      raddr;

  logic                 done_q, done_d;
  olist_pkg::status_e   status_q, status_d;
  logic [WORD_BITS-1:0] rd_q, rd_d;
  logic [IdxW-1:0]      at_q, at_d;

  // Request classification against the current count.
  logic [CntW-1:0] head_pos;
  logic            full_c;
  logic            ins_bad_c;
  logic            ins_end_c;
  logic            idx_bad_c;
  logic            del_last_c;
  logic            up_last_c;
  logic            dn_last_c;
  logic            scan_last_c;
  logic            hit_c;

  always_comb begin
    head_pos    = {1'b0, q_cmd_i.pos};
    full_c      = (cnt_q >= cap_q);
    ins_bad_c   = (head_pos > cnt_q);
    ins_end_c   = (head_pos == cnt_q);
    idx_bad_c   = (head_pos >= cnt_q);
    del_last_c  = ((head_pos + CntW'(1)) == cnt_q);
    up_last_c   = ((ptr_q - 1'b1) == cur_q.pos);
    dn_last_c   = (({1'b0, ptr_q} + CntW'(2)) == cnt_q);
    scan_last_c = (({1'b0, ptr_q} + CntW'(1)) == cnt_q);
    hit_c       = (rdata_q == word_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      olist_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          unique case (q_cmd_i.op)
            olist_pkg::OP_INSERT: begin
              if (!full_c && !ins_bad_c && !ins_end_c) state_d = olist_pkg::BK_SHIFT_UP;
            end
            olist_pkg::OP_DELETE: begin
              if (!idx_bad_c && !del_last_c) state_d = olist_pkg::BK_SHIFT_DN;
            end
            olist_pkg::OP_GET: begin
              if (!idx_bad_c) state_d = olist_pkg::BK_READ;
            end
            olist_pkg::OP_SEARCH: begin
              if (cnt_q != '0) state_d = olist_pkg::BK_SCAN;
            end
            default: ;
          endcase
        end
      end
      olist_pkg::BK_READ:     state_d = olist_pkg::BK_IDLE;
      olist_pkg::BK_SHIFT_UP: if (up_last_c) state_d = olist_pkg::BK_PLACE;
      olist_pkg::BK_PLACE:    state_d = olist_pkg::BK_IDLE;
      olist_pkg::BK_SHIFT_DN: if (dn_last_c) state_d = olist_pkg::BK_IDLE;
      olist_pkg::BK_SCAN:     if (hit_c || scan_last_c) state_d = olist_pkg::BK_IDLE;
      default:                state_d = olist_pkg::BK_IDLE;
    endcase
  end

  // Datapath, memory port and result controls.
  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    waddr    = ptr_q;
    wdata    = rdata_q;
    raddr    = ptr_q;
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    word_d   = word_q;
    done_d   = 1'b0;
    status_d = olist_pkg::ST_OK;
    rd_d     = '0;
    at_d     = '0;
    unique case (state_q)
      olist_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          word_d  = q_word_i;
          unique case (q_cmd_i.op)
            olist_pkg::OP_APPEND: begin
              done_d = 1'b1;
              if (full_c) begin
                status_d = olist_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                waddr  = cnt_q[IdxW-1:0];
                wdata  = q_word_i;
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            olist_pkg::OP_INSERT: begin
              if (full_c) begin
                done_d   = 1'b1;
                status_d = olist_pkg::ST_FULL;
              end else if (ins_bad_c) begin
                done_d   = 1'b1;
                status_d = olist_pkg::ST_BADIDX;
              end else if (ins_end_c) begin
                done_d = 1'b1;
                mem_we = 1'b1;
                waddr  = q_cmd_i.pos;
                wdata  = q_word_i;
                cnt_d  = cnt_q + CntW'(1);
              end else begin
                // top entry first: read cnt-1, later written to cnt
                raddr = IdxW'(cnt_q - CntW'(1));
                ptr_d = cnt_q[IdxW-1:0];
              end
            end
            olist_pkg::OP_EDIT: begin
              done_d = 1'b1;
              if (idx_bad_c) begin
                status_d = olist_pkg::ST_BADIDX;
              end else begin
                mem_we = 1'b1;
                waddr  = q_cmd_i.pos;
                wdata  = q_word_i;
              end
            end
            olist_pkg::OP_DELETE: begin
              if (idx_bad_c) begin
                done_d   = 1'b1;
                status_d = olist_pkg::ST_BADIDX;
              end else if (del_last_c) begin
                done_d = 1'b1;
                cnt_d  = cnt_q - CntW'(1);
              end else begin
                raddr = q_cmd_i.pos + 1'b1;
                ptr_d = q_cmd_i.pos;
              end
            end
            olist_pkg::OP_GET: begin
              raddr = q_cmd_i.pos;
              if (idx_bad_c) begin
                done_d   = 1'b1;
                status_d = olist_pkg::ST_BADIDX;
              end
            end
            olist_pkg::OP_SEARCH: begin
              raddr = '0;
              ptr_d = '0;
              if (cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = olist_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      olist_pkg::BK_READ: begin
        done_d = 1'b1;
        rd_d   = rdata_q;
      end
      olist_pkg::BK_SHIFT_UP: begin
        mem_we = 1'b1;
        waddr  = ptr_q;
        wdata  = rdata_q;
        raddr  = ptr_q - IdxW'(2);
        ptr_d  = ptr_q - 1'b1;
      end
      olist_pkg::BK_PLACE: begin
        mem_we = 1'b1;
        waddr  = cur_q.pos;
        wdata  = word_q;
        cnt_d  = cnt_q + CntW'(1);
        done_d = 1'b1;
      end
      olist_pkg::BK_SHIFT_DN: begin
        mem_we = 1'b1;
        waddr  = ptr_q;
        wdata  = rdata_q;
        raddr  = ptr_q + IdxW'(2);
        ptr_d  = ptr_q + 1'b1;
        if (dn_last_c) begin
          done_d = 1'b1;
          cnt_d  = cnt_q - CntW'(1);
        end
      end
      olist_pkg::BK_SCAN: begin
        raddr = ptr_q + 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (hit_c) begin
          done_d = 1'b1;
          at_d   = ptr_q;
        end else if (scan_last_c) begin
          done_d   = 1'b1;
          status_d = olist_pkg::ST_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  // Capacity clamp: zero acts as one, anything above the depth as the depth.
  always_comb begin
    cap_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      cap_d = CntW'(1);
    end else if (cfg_data_i > CntW'(olist_pkg::Depth)) begin
      cap_d = CntW'(olist_pkg::Depth);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olist_pkg::BK_IDLE;
      cnt_q   <= '0;
      cap_q   <= CntW'(olist_pkg::Depth);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cap_q <= cap_d;
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    cur_q    <= cur_d;
    word_q   <= word_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    at_q     <= at_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign idle_o       = (state_q == olist_pkg::BK_IDLE) && !done_q;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_word_o  = rd_q;
  assign found_at_o   = at_q;
  // The count register settles at the same edge as the strobe.
  assign fill_count_o = cnt_q;
  assign is_full_o    = (cnt_q == cap_q);
  assign is_empty_o   = (cnt_q == '0);

endmodule

[hdl/ordered_array_list_unit.sv]
// ordered_array_list_unit: bounded ordered list of signed words (top level).
// Append, edit, no-op, rejected items, end insert and last-entry delete finish on intake; get
// adds a read step; mid insert shifts entries up, then places; delete shifts entries down.
// Throughput: one item a cycle for single-step items; the entry memory has one write port and
// one registered read port and handles one entry per cycle, pacing insert, delete and search.
// Reset (async, active low) empties the list, sets capacity to 64; entries are not cleared.
`timescale 1ns / 1ps

module ordered_array_list_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write: capacity, also empties the list.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [olist_pkg::CntW-1:0]         cfg_data_i,
  // Request side.
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [2:0]                         mode_i,
  input  logic [olist_pkg::IdxW-1:0]         position_i,
  input  logic signed [WORD_BITS-1:0]        word_in_i,
  // Result side, one strobe per item, cannot be held off.
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic signed [WORD_BITS-1:0]        read_word_o,
  output logic [olist_pkg::IdxW-1:0]         found_at_o,
  output logic [olist_pkg::CntW-1:0]         fill_count_o,
  output logic                               is_full_o,
  output logic                               is_empty_o
);

  // Front end <-> queue
  logic                 push;
  olist_pkg::cmd_t      push_cmd;
  logic                 q_full;
  logic                 q_empty;
  // Queue <-> back end
  olist_pkg::cmd_t      head_cmd;
  logic [WORD_BITS-1:0] head_word;
  logic                 pop;
  logic                 back_idle;
  olist_pkg::status_e   status;
  logic [WORD_BITS-1:0] read_word;
  logic                 cfg_we;

  // Capacity may change only with nothing queued or in flight.
  assign cfg_ready_o = back_idle && q_empty;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  olist_front u_front (
    .start_i    (start_i),
    .mode_i     (mode_i),
    .position_i (position_i),
    .q_full_i   (q_full),
    .busy_o     (busy_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Two-item queue lets intake keep going while the back end walks the memory.
  olist_queue #(
    .WORD_BITS (WORD_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .push_word_i (word_in_i),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_cmd_o  (head_cmd),
    .head_word_o (head_word)
  );

  olist_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data_i),
    .q_empty_i    (q_empty),
    .q_cmd_i      (head_cmd),
    .q_word_i     (head_word),
    .q_pop_o      (pop),
    .idle_o       (back_idle),
    .done_o       (done_o),
    .status_o     (status),
    .read_word_o  (read_word),
    .found_at_o   (found_at_o),
    .fill_count_o (fill_count_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o)
  );

  assign status_o    = status;
  assign read_word_o = read_word;

  // A full status can only come from a list at capacity.
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == olist_pkg::ST_FULL)) |-> is_full_o)
    else $error("full status without full flag");

  // Failed items (full, bad index, miss) report zero data.
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != olist_pkg::ST_OK)) |-> ((found_at_o == '0) && (read_word_o == '0)))
    else $error("nonzero data on failed item");

  // An accepted item is held in the queue on the next cycle.
  a_push_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !q_empty)
    else $error("accepted item missing from queue");

  // Count never exceeds the store depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_count_o <= olist_pkg::CntW'(olist_pkg::Depth))
    else $error("fill count above depth");

endmodule

[tb/olist_result_checker.sv]
// olist_result_checker: predicts and checks every result of ordered_array_list_unit.
// Depends on olist_pkg for widths, request codes and status codes.
`timescale 1ns / 1ps

module olist_result_checker #(
  parameter int unsigned WordW = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [olist_pkg::CntW-1:0] cfg_data_i,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [2:0]                 mode_i,
  input  logic [olist_pkg::IdxW-1:0] position_i,
  input  logic [WordW-1:0]           word_in_i,
  input  logic                       done_i,
  input  logic [1:0]                 status_i,
  input  logic [WordW-1:0]           read_word_i,
  input  logic [olist_pkg::IdxW-1:0] found_at_i,
  input  logic [olist_pkg::CntW-1:0] fill_count_i,
  input  logic                       is_full_i,
  input  logic                       is_empty_i,
  output int                         error_count_o,
  output int                         pending_o,
  output int                         list_fill_o
);

  typedef struct packed {
    olist_pkg::status_e         status;
    logic [WordW-1:0]           read_word;
    logic [olist_pkg::IdxW-1:0] found_at;
    logic [olist_pkg::CntW-1:0] fill;
    logic                       full;
    logic                       empty;
  } list_result_t;

  logic [WordW-1:0] list_words [olist_pkg::Depth];
  int unsigned      list_len;
  int unsigned      capacity;
  list_result_t     expected_q [$];

  // Apply one request to the shadow list and return the result it must give.
  function automatic list_result_t apply_request(input logic [2:0] m, input int unsigned p,
                                                 input logic [WordW-1:0] w);
    list_result_t r;
    int unsigned  lim;
    int           j;
    lim = (capacity < 1) ? 1 :
          ((capacity > olist_pkg::Depth) ? olist_pkg::Depth : capacity);
    r = '0;
    r.status = olist_pkg::ST_OK;
    case (m)
      olist_pkg::MODE_APPEND: begin
        if (list_len >= lim) r.status = olist_pkg::ST_FULL;
        else begin
          list_words[list_len] = w;
          list_len++;
        end
      end
      olist_pkg::MODE_INSERT: begin
        if (list_len >= lim) r.status = olist_pkg::ST_FULL;
        else if (p > list_len) r.status = olist_pkg::ST_BADIDX;
        else begin
          for (j = int'(list_len); j > int'(p); j--) list_words[j] = list_words[j-1];
          list_words[p] = w;
          list_len++;
        end
      end
      olist_pkg::MODE_EDIT: begin
        if (p >= list_len) r.status = olist_pkg::ST_BADIDX;
        else list_words[p] = w;
      end
      olist_pkg::MODE_DELETE: begin
        if (p >= list_len) r.status = olist_pkg::ST_BADIDX;
        else begin
          for (j = int'(p); j + 1 < int'(list_len); j++) list_words[j] = list_words[j+1];
          list_len--;
        end
      end
      olist_pkg::MODE_GET: begin
        if (p >= list_len) r.status = olist_pkg::ST_BADIDX;
        else r.read_word = list_words[p];
      end
      olist_pkg::MODE_SEARCH: begin
        r.status = olist_pkg::ST_NOTFOUND;
        for (j = 0; j < int'(list_len); j++) begin
          if (r.status == olist_pkg::ST_NOTFOUND && list_words[j] == w) begin
            r.status   = olist_pkg::ST_OK;
            r.found_at = olist_pkg::IdxW'(j);
          end
        end
      end
      default: ;
    endcase
    r.fill  = olist_pkg::CntW'(list_len);
    r.full  = (list_len == lim);
    r.empty = (list_len == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      error_count_o++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      capacity = olist_pkg::Depth;
      expected_q.delete();
    end else begin
      // Results come out only after their item has passed the queue and the back end, so check first.
      if (done_i) begin
        if (expected_q.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected result: expected none, got status %0d fill %0d",
                   $time, status_i, fill_count_i);
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("read_word", 64'(want.read_word), 64'(read_word_i));
          check_field("found_at", 64'(want.found_at), 64'(found_at_i));
          check_field("fill_count", 64'(want.fill), 64'(fill_count_i));
          check_field("is_full", 64'(want.full), 64'(is_full_i));
          check_field("is_empty", 64'(want.empty), 64'(is_empty_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        capacity = 32'(cfg_data_i);
        list_len = 0;
      end
      if (start_i && !busy_i) begin
        expected_q.push_back(apply_request(mode_i, 32'(position_i), word_in_i));
      end
    end
    pending_o   = expected_q.size();
    list_fill_o = int'(list_len);
  end

endmodule

[tb/ordered_array_list_unit_tb.sv]
// ordered_array_list_unit_tb: stimulus, watchdog and verdict for ordered_array_list_unit.
// Depends on olist_pkg, the unit itself and olist_result_checker, which does all result checking.
`timescale 1ns / 1ps

module ordered_array_list_unit_tb;

  localparam int unsigned WordW = 32;
  // Mode codes the unit must treat as no-ops.
  localparam logic [2:0] ModeSpare0 = 3'd6;
  localparam logic [2:0] ModeSpare1 = 3'd7;
  // Cycles without any handshake before the run is declared hung. The slowest
  // items (insert at the head of a 63-entry list, search miss on 64) stay far below it.
  localparam int unsigned WatchdogLimit = 3000;
  // Settle time after the last result before a capacity write, and at the end.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 80;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [olist_pkg::CntW-1:0]    cfg_data_i;
  logic                          start_i;
  logic                          busy_o;
  logic [2:0]                    mode_i;
  logic [olist_pkg::IdxW-1:0]    position_i;
  logic signed [WordW-1:0]       word_in_i;
  logic                          done_o;
  logic [1:0]                    status_o;
  logic signed [WordW-1:0]       read_word_o;
  logic [olist_pkg::IdxW-1:0]    found_at_o;
  logic [olist_pkg::CntW-1:0]    fill_count_o;
  logic                          is_full_o;
  logic                          is_empty_o;

  int          check_errors;
  int          results_pending;
  int          list_fill;
  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned cap_writes;
  int unsigned quiet_cycles;
  logic        item_taken;
  logic        cfg_taken;
  logic [WordW-1:0] word_pool [$];

  ordered_array_list_unit #(
    .WORD_BITS (WordW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .word_in_i    (word_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_word_o  (read_word_o),
    .found_at_o   (found_at_o),
    .fill_count_o (fill_count_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o)
  );

  olist_result_checker #(
    .WordW (WordW)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .word_in_i     (word_in_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .read_word_i   (read_word_o),
    .found_at_i    (found_at_o),
    .fill_count_i  (fill_count_o),
    .is_full_i     (is_full_o),
    .is_empty_i    (is_empty_o),
    .error_count_o (check_errors),
    .pending_o     (results_pending),
    .list_fill_o   (list_fill)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Handshakes are registered at the rising edge, so the driving code, which
  // runs at the falling edge, never races the unit's own updates.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_taken   <= 1'b0;
      cfg_taken    <= 1'b0;
      results_seen <= 0;
    end else begin
      item_taken <= start_i && !busy_o;
      cfg_taken  <= cfg_valid_i && cfg_ready_o;
      if (done_o) results_seen <= results_seen + 1;
    end
  end

  // Watchdog: any item, result or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, after a random idle gap, and hold it until taken.
  // start stays high between back-to-back items.
  task automatic send_item(input logic [2:0] m, input int unsigned p,
                           input logic [WordW-1:0] w);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(negedge clk_i);
    end
    start_i    <= 1'b1;
    mode_i     <= m;
    position_i <= olist_pkg::IdxW'(p);
    word_in_i  <= w;
    @(negedge clk_i);
    while (!item_taken) @(negedge clk_i);
    items_sent++;
  endtask

  // Capacity writes only once the list has answered every item.
  task automatic write_capacity(input int unsigned c);
    start_i <= 1'b0;
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= olist_pkg::CntW'(c);
    @(negedge clk_i);
    while (!cfg_taken) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_writes++;
  endtask

  // Word values: extremes, repeats of recently stored words (so searches hit
  // and duplicates exercise first-match), and plain random words.
  function automatic logic [WordW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (r < 50 && word_pool.size() != 0) return word_pool[$urandom_range(0, word_pool.size() - 1)];
    return $urandom;
  endfunction

  // Mostly well-formed requests aimed at the current fill; some noise on
  // the position and on the mode.
  task automatic random_item(input int unsigned add_pct);
    int unsigned      r;
    int unsigned      fill;
    logic [2:0]       m;
    int unsigned      p;
    logic [WordW-1:0] w;
    fill = $unsigned(list_fill);
    r    = $urandom_range(0, 99);
    w    = pick_word();
    if (r < add_pct) m = $urandom_range(0, 1) ? olist_pkg::MODE_INSERT : olist_pkg::MODE_APPEND;
    else if (r < add_pct + 15) m = olist_pkg::MODE_DELETE;
    else if (r < 97) begin
      case ($urandom_range(0, 2))
        0:       m = olist_pkg::MODE_EDIT;
        1:       m = olist_pkg::MODE_GET;
        default: m = olist_pkg::MODE_SEARCH;
      endcase
    end else m = $urandom_range(0, 1) ? ModeSpare1 : ModeSpare0;
    if ($urandom_range(0, 99) < 12) p = $urandom_range(0, olist_pkg::Depth - 1);
    else if (m == olist_pkg::MODE_INSERT) begin
      p = $urandom_range(0, (fill < olist_pkg::Depth) ? fill : olist_pkg::Depth - 1);
    end else p = (fill == 0) ? 0 : $urandom_range(0, fill - 1);
    if (m == olist_pkg::MODE_APPEND || m == olist_pkg::MODE_INSERT ||
        m == olist_pkg::MODE_EDIT) begin
      word_pool.push_back(w);
      if (word_pool.size() > 16) void'(word_pool.pop_front());
    end
    send_item(m, p, w);
  endtask

  task automatic run_phase(input int unsigned cap, input int unsigned idle,
                           input int unsigned count, input int unsigned add_pct);
    write_capacity(cap);
    idle_pct = idle;
    repeat (count) random_item(add_pct);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    start_i     = 1'b0;
    mode_i      = olist_pkg::MODE_APPEND;
    position_i  = '0;
    word_in_i   = '0;
    idle_pct    = 30;
    items_sent  = 0;
    cap_writes  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset capacity of 64.
    // Everything that needs an entry on an empty list must be rejected.
    send_item(olist_pkg::MODE_GET, 0, 32'h1111_1111);
    send_item(olist_pkg::MODE_EDIT, 0, 32'h2222_2222);
    send_item(olist_pkg::MODE_DELETE, 63, 32'h0);
    send_item(olist_pkg::MODE_SEARCH, 0, 32'h0);
    send_item(olist_pkg::MODE_INSERT, 1, 32'h3333_3333);   // insert past the end
    // Build a list of extreme values, inserting at head, end and middle.
    send_item(olist_pkg::MODE_INSERT, 0, 32'h8000_0000);
    send_item(olist_pkg::MODE_APPEND, 0, 32'h7FFF_FFFF);
    send_item(olist_pkg::MODE_APPEND, 0, 32'h0000_0000);
    send_item(olist_pkg::MODE_APPEND, 0, 32'hFFFF_FFFF);
    send_item(olist_pkg::MODE_INSERT, 4, 32'h5555_5555);   // insert exactly at the end
    send_item(olist_pkg::MODE_INSERT, 2, 32'hAAAA_AAAA);
    send_item(olist_pkg::MODE_GET, 63, 32'h0);             // index far out of range
    send_item(olist_pkg::MODE_GET, 5, 32'h0);
    send_item(olist_pkg::MODE_SEARCH, 0, 32'hFFFF_FFFF);
    send_item(olist_pkg::MODE_SEARCH, 0, 32'h1234_5678);   // miss
    send_item(olist_pkg::MODE_EDIT, 1, 32'h0F0F_0F0F);
    send_item(olist_pkg::MODE_INSERT, 7, 32'h6666_6666);   // one past the end
    send_item(olist_pkg::MODE_DELETE, 0, 32'h0);
    send_item(olist_pkg::MODE_DELETE, 4, 32'h0);           // last entry
    send_item(ModeSpare0, 0, 32'h0);
    send_item(ModeSpare1, 63, 32'h7FFF_FFFF);
    send_item(olist_pkg::MODE_APPEND, 0, 32'h7FFF_FFFF);   // re-adds the value that the edit overwrote
    send_item(olist_pkg::MODE_SEARCH, 0, 32'h7FFF_FFFF);   // must find it at the new last entry
    // Capacity zero behaves as one: full takes priority over a bad index.
    write_capacity(0);
    send_item(olist_pkg::MODE_APPEND, 0, 32'hC0DE_0001);
    send_item(olist_pkg::MODE_APPEND, 0, 32'hC0DE_0002);
    send_item(olist_pkg::MODE_INSERT, 63, 32'hC0DE_0003);
    send_item(olist_pkg::MODE_DELETE, 0, 32'h0);

    // Random part: a small list to hit full often, capacity above the store depth
    // with heavy adds to fill all 64 entries, then capacities 1, 3, 64 and 20.
    run_phase(8, 30, 100, 45);
    run_phase(127, 30, 110, 70);
    run_phase(1, 61, 40, 45);
    run_phase(3, 61, 70, 45);
    run_phase(64, 0, 100, 55);
    run_phase(20, 0, 60, 40);

    start_i <= 1'b0;
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Run covered %0d items, %0d results and %0d capacity writes.",
             items_sent, results_seen, cap_writes);
    $display("Capacities 64, 0, 8, 127, 1, 3, 64, 20; sender gaps 30%%, 61%% and none.");
    if (check_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/olist_pkg.sv
hdl/olist_front.sv
hdl/olist_queue.sv
hdl/olist_back.sv
hdl/ordered_array_list_unit.sv
tb/olist_result_checker.sv
tb/ordered_array_list_unit_tb.sv
